// ----- hdl/dmb_pkg.sv -----
// ----------------------------------------------------------------------------
// dmb_pkg
// shared constants for the diagonal motion blur block
// ----------------------------------------------------------------------------
package dmb_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_HALF  = 7;

  localparam int HEIGHT_LIMIT  = 4096;
  localparam int HT_W          = 13;   // effective frame height value
  localparam int IROW_W        = 13;   // input row counter
  localparam int OROW_W        = 12;   // output row counter
  localparam int CH_W          = 8;
  localparam int PIX_W         = 3 * CH_W;

  // configuration port
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 13;
  localparam int HALF_CFG_W    = 3;
  localparam int WIDTH_CFG_W   = 12;
  localparam int HEIGHT_CFG_W  = 13;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [HALF_CFG_W-1:0]   RST_HALF_WIDTH   = 3'd1;
  localparam logic [WIDTH_CFG_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
  localparam logic [HEIGHT_CFG_W-1:0] RST_FRAME_HEIGHT = 13'd480;

endpackage

// ----- hdl/dmb_queue.sv -----
// ----------------------------------------------------------------------------
// dmb_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module dmb_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);

  localparam int DEPTH = 2;

  logic [DATA_W-1:0] slots [DEPTH];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pull;

  assign full      = (count == 2'(DEPTH));
  assign pop_valid = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];
  assign push      = push_valid && !full;
  assign pull      = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pull) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pull);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH)) else $error("queue count overflow");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pull) |=> count == $past(count) + 2'd1) else $error("push lost");

  a_pop_grows_not: assert property (@(posedge clk) disable iff (rst)
    (pull && !push) |=> count == $past(count) - 2'd1) else $error("pop lost");

endmodule

// ----- hdl/dmb_front.sv -----
// ----------------------------------------------------------------------------
// dmb_front
// accepts words, keeps frame positions, classifies each into a job
// ----------------------------------------------------------------------------
module dmb_front #(
  parameter int MAX_WIDTH = dmb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF  = dmb_pkg::DEF_MAX_HALF,
  parameter int WID_W     = $clog2(MAX_WIDTH + 1),
  parameter int LIN_W     = dmb_pkg::IROW_W + WID_W + 1,
  parameter int JOB_W     = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [dmb_pkg::CH_W-1:0]  blue_in,
  input  logic [dmb_pkg::CH_W-1:0]  green_in,
  input  logic [dmb_pkg::CH_W-1:0]  red_in,
  input  logic                      padding,
  input  logic [WID_W-1:0]          eff_w,
  input  logic [dmb_pkg::HT_W-1:0]  eff_ht,
  input  logic [LIN_W-1:0]          delay,
  input  logic [LIN_W-1:0]          total,
  output logic                      job_valid,
  output logic [JOB_W-1:0]          job_data,
  input  logic                      job_full
);
  import dmb_pkg::*;

  localparam int RING   = 2 * MAX_HALF + 2;
  localparam int SLOT_W = $clog2(RING);
  localparam int COL_W  = $clog2(MAX_WIDTH);

  localparam logic [1:0] F_TAKE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DEC  = 2'd2;

  logic [1:0]        state;
  logic [PIX_W-1:0]  pix;
  logic              pad;
  logic [COL_W-1:0]  in_col;
  logic [IROW_W-1:0] in_row;
  logic [SLOT_W-1:0] in_slot;
  logic [COL_W-1:0]  out_col;
  logic [OROW_W-1:0] out_row;
  logic [SLOT_W-1:0] out_slot;
  logic [LIN_W-1:0]  lin_in;
  logic [LIN_W-1:0]  lin_out;

  logic              bad;
  logic [COL_W-1:0]  u_ic;
  logic [IROW_W-1:0] u_ir;
  logic [SLOT_W-1:0] u_is;
  logic [COL_W-1:0]  u_oc;
  logic [OROW_W-1:0] u_or;
  logic [SLOT_W-1:0] u_os;
  logic [LIN_W-1:0]  u_li;
  logic              wr;
  logic              emit;
  logic              last;
  logic              commit;
  logic [COL_W-1:0]  in_col_next;
  logic [IROW_W-1:0] in_row_next;
  logic [SLOT_W-1:0] in_slot_next;
  logic [COL_W-1:0]  out_col_next;
  logic [OROW_W-1:0] out_row_next;
  logic [SLOT_W-1:0] out_slot_next;

  assign in_stall = (state != F_TAKE);

  always_comb begin
    bad = (WID_W'(in_col) >= eff_w) || (WID_W'(out_col) >= eff_w) ||
          (HT_W'(out_row) >= eff_ht) ||
          ((lin_out == '0) ? (lin_in > delay) : (lin_in != lin_out + delay));
    u_ic = bad ? '0 : in_col;
    u_ir = bad ? '0 : in_row;
    u_is = bad ? '0 : in_slot;
    u_oc = bad ? '0 : out_col;
    u_or = bad ? '0 : out_row;
    u_os = bad ? '0 : out_slot;
    u_li = bad ? '0 : lin_in;
    wr   = (u_li < total);
    emit = (u_li >= delay);
    last = (HT_W'(u_or) == eff_ht - HT_W'(1)) && (WID_W'(u_oc) == eff_w - WID_W'(1));

    // advance input position
    if (WID_W'(u_ic) + WID_W'(1) >= eff_w) begin
      in_col_next  = '0;
      in_row_next  = u_ir + IROW_W'(1);
      in_slot_next = (int'(u_is) == RING - 1) ? '0 : u_is + SLOT_W'(1);
    end else begin
      in_col_next  = u_ic + COL_W'(1);
      in_row_next  = u_ir;
      in_slot_next = u_is;
    end

    // advance output position
    out_col_next  = u_oc;
    out_row_next  = u_or;
    out_slot_next = u_os;
    if (emit) begin
      if (WID_W'(u_oc) + WID_W'(1) >= eff_w) begin
        out_col_next  = '0;
        out_row_next  = u_or + OROW_W'(1);
        out_slot_next = (int'(u_os) == RING - 1) ? '0 : u_os + SLOT_W'(1);
      end else begin
        out_col_next  = u_oc + COL_W'(1);
      end
    end
  end

  assign job_valid = (state == F_DEC);
  assign commit    = job_valid && !job_full;
  assign job_data  = {wr, u_is, u_ic, (pad ? PIX_W'(0) : pix),
                      emit, u_os, u_or, u_oc, last};

  always_ff @(posedge clk) begin
    if (state == F_TAKE && in_valid) begin
      pix <= {red_in, green_in, blue_in};
      pad <= padding;
    end
    if (state == F_MUL) begin
      lin_in  <= LIN_W'(in_row) * LIN_W'(eff_w) + LIN_W'(in_col);
      lin_out <= LIN_W'(out_row) * LIN_W'(eff_w) + LIN_W'(out_col);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_TAKE;
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
    end else begin
      unique case (state)
        F_TAKE: if (in_valid) state <= F_MUL;
        F_MUL:  state <= F_DEC;
        F_DEC: begin
          if (commit) begin
            state <= F_TAKE;
            if (emit && last) begin
              in_col   <= '0;
              in_row   <= '0;
              in_slot  <= '0;
              out_col  <= '0;
              out_row  <= '0;
              out_slot <= '0;
            end else begin
              in_col   <= in_col_next;
              in_row   <= in_row_next;
              in_slot  <= in_slot_next;
              out_col  <= out_col_next;
              out_row  <= out_row_next;
              out_slot <= out_slot_next;
            end
          end
        end
        default: state <= F_TAKE;
      endcase
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    int'(in_slot) < RING && int'(out_slot) < RING) else $error("ring slot out of range");

  a_col_hold: assert property (@(posedge clk) disable iff (rst)
    (state == F_DEC && job_full) |=> $stable(in_col) && $stable(out_col))
    else $error("position moved while queue full");

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    (state == F_MUL) |-> $past(state) == F_TAKE) else $error("bad front sequence");

endmodule

// ----- hdl/dmb_back.sv -----
// ----------------------------------------------------------------------------
// dmb_back
// line store, plus diagonal tap sum and divider for each job with a result
// ----------------------------------------------------------------------------
module dmb_back #(
  parameter int MAX_WIDTH = dmb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF  = dmb_pkg::DEF_MAX_HALF,
  parameter int WID_W     = $clog2(MAX_WIDTH + 1),
  parameter int HALF_W    = $clog2(MAX_HALF + 1),
  parameter int JOB_W     = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      job_valid,
  input  logic [JOB_W-1:0]          job_data,
  output logic                      job_pop,
  input  logic [WID_W-1:0]          eff_w,
  input  logic [dmb_pkg::HT_W-1:0]  eff_ht,
  input  logic [HALF_W-1:0]         eff_h,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [dmb_pkg::CH_W-1:0]  blue_out,
  output logic [dmb_pkg::CH_W-1:0]  green_out,
  output logic [dmb_pkg::CH_W-1:0]  red_out,
  output logic                      frame_end
);
  import dmb_pkg::*;

  localparam int RING   = 2 * MAX_HALF + 2;
  localparam int SLOT_W = $clog2(RING);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int DEPTH  = RING * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SUM_W  = $clog2((2 * MAX_HALF + 1) * 255 + 1);
  localparam int CAND_W = SUM_W + CH_W;
  localparam int TR_W   = OROW_W + 2;
  localparam int TC_W   = WID_W + 2;
  localparam int CNT_W  = $clog2(2 * MAX_HALF + 2);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_WR   = 3'd1;
  localparam logic [2:0] B_TAP  = 3'd2;
  localparam logic [2:0] B_LAST = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  logic [2:0]              state;
  logic                    j_wr;
  logic [SLOT_W-1:0]       j_wslot;
  logic [COL_W-1:0]        j_wcol;
  logic [PIX_W-1:0]        j_pix;
  logic                    j_emit;
  logic [SLOT_W-1:0]       j_oslot;
  logic [OROW_W-1:0]       j_orow;
  logic [COL_W-1:0]        j_ocol;
  logic                    j_last;

  logic [PIX_W-1:0]        mem [DEPTH];
  logic [PIX_W-1:0]        rd_q;
  logic                    hit_q;
  logic signed [TR_W-1:0]  tr;
  logic signed [TC_W-1:0]  tc;
  logic [SLOT_W-1:0]       tslot;
  logic [CNT_W-1:0]        cnt;
  logic                    hit;
  logic [ADDR_W-1:0]       waddr;
  logic [ADDR_W-1:0]       raddr;
  logic [SUM_W-1:0]        sum_b;
  logic [SUM_W-1:0]        sum_g;
  logic [SUM_W-1:0]        sum_r;
  logic [CH_W-1:0]         q_b;
  logic [CH_W-1:0]         q_g;
  logic [CH_W-1:0]         q_r;
  logic [2:0]              step;
  logic [CAND_W-1:0]       cand;
  logic [SLOT_W-1:0]       start_slot;

  assign job_pop   = (state == B_IDLE) && job_valid;
  assign out_valid = (state == B_OUT);
  assign blue_out  = q_b;
  assign green_out = q_g;
  assign red_out   = q_r;
  assign frame_end = j_last;

  assign hit = (tr >= 0) && (tc >= 0) &&
               (tr < signed'(TR_W'(eff_ht))) && (tc < signed'(TC_W'(eff_w)));
  assign waddr = ADDR_W'(j_wslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(j_wcol);
  assign raddr = ADDR_W'(tslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(tc[COL_W-1:0]);
  assign cand  = CAND_W'({1'b0, eff_h, 1'b1}) << step;
  assign start_slot = (int'(j_oslot) >= int'(eff_h)) ? j_oslot - SLOT_W'(eff_h)
                    : SLOT_W'(int'(j_oslot) + RING - int'(eff_h));

  // line store
  always_ff @(posedge clk) begin
    if (state == B_WR && j_wr) begin
      mem[waddr] <= j_pix;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      {j_wr, j_wslot, j_wcol, j_pix, j_emit, j_oslot, j_orow, j_ocol, j_last} <= job_data;
    end
    unique case (state)
      B_WR: begin
        tr    <= signed'(TR_W'(j_orow)) - signed'(TR_W'(eff_h));
        tc    <= signed'(TC_W'(j_ocol)) - signed'(TC_W'(eff_h));
        tslot <= start_slot;
        cnt   <= '0;
      end
      B_TAP: begin
        tr    <= tr + TR_W'(1);
        tc    <= tc + TC_W'(1);
        tslot <= (int'(tslot) == RING - 1) ? '0 : tslot + SLOT_W'(1);
        cnt   <= cnt + CNT_W'(1);
      end
      default: ;
    endcase

    // sums double as remainders while dividing
    priority if (state == B_WR) begin
      sum_b <= '0;
      sum_g <= '0;
      sum_r <= '0;
    end else if (hit_q) begin
      sum_b <= sum_b + SUM_W'(rd_q[CH_W-1:0]);
      sum_g <= sum_g + SUM_W'(rd_q[2*CH_W-1:CH_W]);
      sum_r <= sum_r + SUM_W'(rd_q[3*CH_W-1:2*CH_W]);
    end else if (state == B_DIV) begin
      if (CAND_W'(sum_b) >= cand) sum_b <= sum_b - SUM_W'(cand);
      if (CAND_W'(sum_g) >= cand) sum_g <= sum_g - SUM_W'(cand);
      if (CAND_W'(sum_r) >= cand) sum_r <= sum_r - SUM_W'(cand);
    end else begin
      // sums hold
    end

    if (state == B_LAST) begin
      q_b  <= '0;
      q_g  <= '0;
      q_r  <= '0;
      step <= 3'd7;
    end else if (state == B_DIV) begin
      q_b[step] <= (CAND_W'(sum_b) >= cand);
      q_g[step] <= (CAND_W'(sum_g) >= cand);
      q_r[step] <= (CAND_W'(sum_r) >= cand);
      step      <= step - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      hit_q <= 1'b0;
    end else begin
      hit_q <= (state == B_TAP) && hit;
      unique case (state)
        B_IDLE: if (job_valid) state <= B_WR;
        B_WR:   state <= j_emit ? B_TAP : B_IDLE;
        B_TAP:  if (cnt == CNT_W'({eff_h, 1'b0})) state <= B_LAST;
        B_LAST: state <= B_DIV;
        B_DIV:  if (step == 3'd0) state <= B_OUT;
        B_OUT:  if (!out_stall) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(q_b) && $stable(j_last))
    else $error("result changed while stalled");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !out_valid) else $error("job taken while result pending");

  a_hit_only_taps: assert property (@(posedge clk) disable iff (rst)
    hit_q |-> ($past(state) == B_TAP)) else $error("stray tap accumulate");

endmodule

// ----- hdl/diagonal_motion_blur_rgb_top.sv -----
// ----------------------------------------------------------------------------
// diagonal_motion_blur_rgb_top
// diagonal motion blur over an rgb pixel stream in raster order
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall carry one pixel word (blue_in,
//   green_in, red_in, padding). padding words follow the frame to push out
//   the last h*W+h results that are still held in the line store.
//   output channel: out_valid / out_stall carry one blurred word, with
//   frame_end high on the last pixel of the frame.
//   config: cfg_write, cfg_index, cfg_data write half_width, frame_width,
//   frame_height; write only while the block is idle.
// flow
//   the front takes a word, multiplies its position and classifies it,
//   then pushes the job into a two-entry job queue; it takes no new word
//   until the job enters the queue. the back stores each frame word in the
//   line store and, for a word with a result, makes one line store read per
//   diagonal tap, then an 8-step shift-subtract divide by 2h+1.
//   first result appears h*W+h words after the first pixel.
// reset
//   registers return to h=1, 640x480; position counters clear; the line
//   store needs no clearing since a frame writes every tap before it reads.
// stall
//   a stalled result holds in the back; the queue fills and then the front
//   raises in_stall until the receiver takes the word.
// ----------------------------------------------------------------------------
module diagonal_motion_blur_rgb_top #(
  parameter int MAX_WIDTH = dmb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF  = dmb_pkg::DEF_MAX_HALF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dmb_pkg::CH_W-1:0]       blue_in,
  input  logic [dmb_pkg::CH_W-1:0]       green_in,
  input  logic [dmb_pkg::CH_W-1:0]       red_in,
  input  logic                           padding,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dmb_pkg::CH_W-1:0]       blue_out,
  output logic [dmb_pkg::CH_W-1:0]       green_out,
  output logic [dmb_pkg::CH_W-1:0]       red_out,
  output logic                           frame_end,
  input  logic                           cfg_write,
  input  logic [dmb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dmb_pkg::*;

  localparam int RING   = 2 * MAX_HALF + 2;
  localparam int SLOT_W = $clog2(RING);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HALF_W = $clog2(MAX_HALF + 1);
  localparam int LIN_W  = IROW_W + WID_W + 1;
  // job: write flag, write slot/col, pixel, emit flag, out slot/row/col, last
  localparam int JOB_W  = 1 + SLOT_W + COL_W + PIX_W + 1 + SLOT_W + OROW_W + COL_W + 1;

  logic [HALF_CFG_W-1:0]   half_width;
  logic [WIDTH_CFG_W-1:0]  frame_width;
  logic [HEIGHT_CFG_W-1:0] frame_height;
  logic [WID_W-1:0]        eff_w;
  logic [HT_W-1:0]         eff_ht;
  logic [HALF_W-1:0]       eff_h;
  logic [LIN_W-1:0]        delay;
  logic [LIN_W-1:0]        total;

  logic                    fq_valid;
  logic [JOB_W-1:0]        fq_data;
  logic                    fq_full;
  logic                    qb_valid;
  logic [JOB_W-1:0]        qb_data;
  logic                    qb_pop;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      half_width   <= RST_HALF_WIDTH;
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HALF_WIDTH:   half_width   <= cfg_data[HALF_CFG_W-1:0];
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp registers to what the store and counters can hold; zero sizes count as one
  always_comb begin
    if (frame_width == '0) eff_w = WID_W'(1);
    else if (int'(frame_width) > MAX_WIDTH) eff_w = WID_W'(MAX_WIDTH);
    else eff_w = WID_W'(frame_width);

    if (frame_height == '0) eff_ht = HT_W'(1);
    else if (int'(frame_height) > HEIGHT_LIMIT) eff_ht = HT_W'(HEIGHT_LIMIT);
    else eff_ht = frame_height;

    if (int'(half_width) > MAX_HALF) eff_h = HALF_W'(MAX_HALF);
    else eff_h = HALF_W'(half_width);
  end

  // result lag and frame size in positions
  always_ff @(posedge clk) begin
    delay <= LIN_W'(eff_h) * LIN_W'(eff_w) + LIN_W'(eff_h);
    total <= LIN_W'(eff_w) * LIN_W'(eff_ht);
  end

  dmb_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF),
    .WID_W     (WID_W),
    .LIN_W     (LIN_W),
    .JOB_W     (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .blue_in   (blue_in),
    .green_in  (green_in),
    .red_in    (red_in),
    .padding   (padding),
    .eff_w     (eff_w),
    .eff_ht    (eff_ht),
    .delay     (delay),
    .total     (total),
    .job_valid (fq_valid),
    .job_data  (fq_data),
    .job_full  (fq_full)
  );

  dmb_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_data  (fq_data),
    .full       (fq_full),
    .pop        (qb_pop),
    .pop_valid  (qb_valid),
    .pop_data   (qb_data)
  );

  dmb_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF),
    .WID_W     (WID_W),
    .HALF_W    (HALF_W),
    .JOB_W     (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qb_valid),
    .job_data  (qb_data),
    .job_pop   (qb_pop),
    .eff_w     (eff_w),
    .eff_ht    (eff_ht),
    .eff_h     (eff_h),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .blue_out  (blue_out),
    .green_out (green_out),
    .red_out   (red_out),
    .frame_end (frame_end)
  );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// diagonal motion blur testbench
// drives pixel words through the blur block under random source gaps and
// sink stalls, predicts every blurred word from an independent line store
// model and compares the results field by field in arrival order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dmb_pkg::*;

  localparam int RING = 2 * DEF_MAX_HALF + 2;
  localparam int DRAIN_CYCLES = 80;   // idle wait after the last expected word returns

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CH_W-1:0]       blue_in = '0, green_in = '0, red_in = '0;
  logic                  padding = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CH_W-1:0]       blue_out, green_out, red_out;
  logic                  frame_end;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_HALF_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  diagonal_motion_blur_rgb_top uut (.*);

  // clock: 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic            last;
  } blur_word_t;

  blur_word_t blurred_q[$];

  // shadow of the block's registers and position counters
  int unsigned half_reg = RST_HALF_WIDTH;
  int unsigned width_reg = RST_FRAME_WIDTH;
  int unsigned height_reg = RST_FRAME_HEIGHT;
  int unsigned col_in, row_in, col_out, row_out;
  logic [PIX_W-1:0] line_mem [RING][DEF_MAX_WIDTH];

  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int frames_done = 0;
  bit burst_mode = 0;   // no gaps and no stalls while set

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    return (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
  endfunction

  function automatic int unsigned eff_ht();
    if (height_reg == 0) return 1;
    return (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (half_reg > DEF_MAX_HALF) ? DEF_MAX_HALF : half_reg;
  endfunction

  // advance the shadow by one accepted word and queue the blurred word it yields
  function automatic void blur_predict(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                       logic pad);
    int unsigned w, ht, h, lag, total, lin_in, lin_out, dv;
    int unsigned sb, sg, sr;
    int tr, tc;
    logic [PIX_W-1:0] px;
    blur_word_t res;
    w = eff_w(); ht = eff_ht(); h = eff_h();
    lag = h * w + h;
    total = w * ht;
    lin_in = row_in * w + col_in;
    lin_out = row_out * w + col_out;
    if (col_in >= w || col_out >= w || row_out >= ht ||
        (lin_out == 0 ? lin_in > lag : lin_in != lin_out + lag)) begin
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
      lin_in = 0;
    end
    if (lin_in < total)
      line_mem[row_in % RING][col_in] = pad ? '0 : {r, g, b};
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (lin_in < lag) return;
    sb = 0; sg = 0; sr = 0;
    dv = 2 * h + 1;
    for (int k = -int'(h); k <= int'(h); k++) begin
      tr = int'(row_out) + k;
      tc = int'(col_out) + k;
      if (tr < 0 || tc < 0 || tr >= int'(ht) || tc >= int'(w)) continue;
      px = line_mem[tr % RING][tc];
      sb += px[7:0];
      sg += px[15:8];
      sr += px[23:16];
    end
    res.blue = 8'(sb / dv);
    res.green = 8'(sg / dv);
    res.red = 8'(sr / dv);
    res.last = (row_out == ht - 1) && (col_out == w - 1);
    blurred_q.push_back(res);
    if (res.last) begin
      col_in = 0; row_in = 0; col_out = 0; row_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int p;
    if (burst_mode) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // sink side: random stall, changed only at the falling edge
  initial begin
    int n;
    forever begin
      n = gap_len();
      if (n > 0) begin
        @(negedge clk) out_stall = 1'b1;
        repeat (n - 1) @(negedge clk);
      end
      @(negedge clk) out_stall = 1'b0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    blur_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      words_checked++;
      if (blurred_q.size() == 0) begin
        $display("%0t: unexpected word b=%0d g=%0d r=%0d end=%0b", $realtime,
                 blue_out, green_out, red_out, frame_end);
        errors++;
      end else begin
        exp_w = blurred_q.pop_front();
        if (blue_out !== exp_w.blue) begin
          $display("%0t: blue expected %0d actual %0d", $realtime, exp_w.blue, blue_out);
          errors++;
        end
        if (green_out !== exp_w.green) begin
          $display("%0t: green expected %0d actual %0d", $realtime, exp_w.green,
                   green_out);
          errors++;
        end
        if (red_out !== exp_w.red) begin
          $display("%0t: red expected %0d actual %0d", $realtime, exp_w.red, red_out);
          errors++;
        end
        if (frame_end !== exp_w.last) begin
          $display("%0t: frame_end expected %0b actual %0b", $realtime, exp_w.last,
                   frame_end);
          errors++;
        end
        if (exp_w.last) frames_done++;
      end
    end
  end

  // one word into the block; valid stays up across back-to-back words
  task automatic send_word(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic pad);
    int n;
    @(negedge clk);
    in_valid = 1'b1;
    blue_in = b; green_in = g; red_in = r; padding = pad;
    do @(posedge clk); while (in_stall);
    blur_predict(b, g, r, pad);
    words_sent++;
    n = gap_len();
    if (n > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // wait until every expected word is back and the back end is quiet
  task automatic wait_idle();
    @(negedge clk) in_valid = 1'b0;
    while (blurred_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(val);
    case (idx)
      REG_HALF_WIDTH:   half_reg = val & 32'h7;
      REG_FRAME_WIDTH:  width_reg = val & 32'hFFF;
      REG_FRAME_HEIGHT: height_reg = val & 32'h1FFF;
      default: ;
    endcase
    @(negedge clk) cfg_write = 1'b0;
  endtask

  task automatic set_geometry(int unsigned h, int unsigned w, int unsigned ht);
    wait_idle();
    write_reg(REG_HALF_WIDTH, h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, ht);
  endtask

  function automatic logic [7:0] rand_chan();
    int p;
    p = $urandom_range(9);
    if (p == 0) return 8'h00;
    if (p == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // one full frame plus the trailing words that push out the held results;
  // pad_pct sets black holes inside the frame, tail words are padding or stray pixels
  task automatic run_frame(int pad_pct);
    int unsigned total, lag;
    bit pad;
    total = eff_w() * eff_ht();
    lag = eff_h() * eff_w() + eff_h();
    for (int unsigned i = 0; i < total + lag; i++) begin
      if (i < total) pad = ($urandom_range(99) < pad_pct);
      else pad = ($urandom_range(3) != 0);
      send_word(rand_chan(), rand_chan(), rand_chan(), pad);
    end
  endtask

  // the start of a frame only; the next geometry change restarts the counters
  task automatic run_words(int unsigned count, int pad_pct);
    for (int unsigned i = 0; i < count; i++)
      send_word(rand_chan(), rand_chan(), rand_chan(), $urandom_range(99) < pad_pct);
  endtask

  // directed: extreme values, black holes inside the frame, stray pixels in the tail
  task automatic test_directed();
    set_geometry(1, 4, 3);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(8'h00, 8'h00, 8'h00, 1'b0);
    send_word(8'hAA, 8'h55, 8'hAA, 1'b0);
    send_word(8'h55, 8'hAA, 8'h55, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);     // padding inside the frame is black
    send_word(8'hFF, 8'h00, 8'hFF, 1'b0);
    send_word(8'h00, 8'hFF, 8'h00, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(8'h01, 8'h80, 8'hFE, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(8'h7F, 8'h80, 8'h7F, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(8'h12, 8'h34, 8'h56, 1'b0);     // stray pixels past the frame only drain
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(8'h00, 8'h00, 8'h00, 1'b1);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_word(8'h00, 8'h00, 8'h00, 1'b1);
    // zero sizes count as one pixel
    set_geometry(3, 0, 0);
    run_frame(0);
  endtask

  // register extremes on the first rows of large frames
  task automatic test_extremes();
    set_geometry(0, 4095, 8191);              // width and height saturate, h = 0
    burst_mode = 1;
    run_words(160, 5);
    burst_mode = 0;
    set_geometry(7, 2, 4096);                 // longest kernel, ring wraps many times
    run_words(200, 5);
    set_geometry(7, 4095, 1);                 // lag longer than the words sent
    run_words(40, 0);
  endtask

  // random small frames with random kernels
  task automatic test_random_frames();
    int unsigned start;
    start = words_sent;
    while (words_sent - start < 700) begin
      set_geometry($urandom_range(7), $urandom_range(12, 1), $urandom_range(8, 1));
      burst_mode = ($urandom_range(4) == 0);
      run_frame($urandom_range(3) == 0 ? 20 : 0);
      burst_mode = 0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    test_directed();
    test_extremes();
    test_random_frames();
    wait_idle();
    $display("covered %0d input words and %0d blurred words over %0d frames,", words_sent,
             words_checked, frames_done);
    $display("kernel half widths 0..7 and sizes from 1x1 up to saturated register values");
    if (errors == 0) $display("diagonal_motion_blur_rgb_top regression: pass");
    else $display("diagonal_motion_blur_rgb_top regression: fail");
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("diagonal_motion_blur_rgb_top regression: fail");
    $finish;
  end

endmodule
